[sv/npm_pkg.sv]
// npm_pkg: sizes, codes and shared types of the nearest peak merge block
// no dependencies
package npm_pkg;

    localparam int PEAK_DEPTH   = 256;
    localparam int FILTER_COUNT = 8;
    localparam int COORD_BITS   = 16;

    localparam int IDX_W   = (PEAK_DEPTH > 1) ? $clog2(PEAK_DEPTH) : 1;
    localparam int CNT_W   = $clog2(PEAK_DEPTH + 1);
    localparam int FLAG_W  = FILTER_COUNT;
    localparam int SQ_W    = 2 * COORD_BITS;
    localparam int D2_W    = SQ_W + 1;
    localparam int LIM_W   = 36;
    localparam int CMP_W   = D2_W + 4;

    // fixed port widths
    localparam int ACTION_W    = 2;
    localparam int POS_W       = 16;
    localparam int FLAGS_IO_W  = 8;
    localparam int OUTCOME_W   = 3;
    localparam int ENTRY_IDX_W = 8;
    localparam int PEAK_CNT_W  = 9;
    localparam int APB_DATA_W  = 64;
    localparam int APB_ADDR_W  = 5;

    localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_OFFER = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [OUTCOME_W-1:0] OUT_MERGED  = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_ADDED   = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_DROPPED = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_FULL    = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_LOADED  = 3'd4;

    localparam logic [1:0] REG_SAME_EN  = 2'd0;
    localparam logic [1:0] REG_SAME_LIM = 2'd1;
    localparam logic [1:0] REG_NEW_EN   = 2'd2;
    localparam logic [1:0] REG_NEW_LIM  = 2'd3;

    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  idx;
        logic [D2_W-1:0]   d2;
        logic [FLAG_W-1:0] flags;
    } best_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } rd_tag_t;

endpackage

[sv/npm_store.sv]
// npm_store: peak position and flag memory, one write port, one registered read port
// depends on npm_pkg
module npm_store
    import npm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_pos_en,
    input  logic                  wr_flag_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  logic [COORD_BITS-1:0] wr_x,
    input  logic [COORD_BITS-1:0] wr_y,
    input  logic [FLAG_W-1:0]     wr_flags,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_addr,
    output logic [COORD_BITS-1:0] rd_x,
    output logic [COORD_BITS-1:0] rd_y,
    output logic [FLAG_W-1:0]     rd_flags,
    output rd_tag_t               rd_tag
);

    logic [COORD_BITS-1:0] x_mem [PEAK_DEPTH];
    logic [COORD_BITS-1:0] y_mem [PEAK_DEPTH];
    logic [FLAG_W-1:0]     f_mem [PEAK_DEPTH];

    logic [COORD_BITS-1:0] rd_x_reg;
    logic [COORD_BITS-1:0] rd_y_reg;
    logic [FLAG_W-1:0]     rd_flags_reg;
    rd_tag_t               rd_tag_reg;

    always_ff @(posedge clk)
    begin
        if (wr_pos_en)
        begin
            x_mem[wr_addr] <= wr_x;
            y_mem[wr_addr] <= wr_y;
        end
        if (wr_flag_en)
        begin
            f_mem[wr_addr] <= wr_flags;
        end
        if (rd_en)
        begin
            rd_x_reg     <= x_mem[rd_addr];
            rd_y_reg     <= y_mem[rd_addr];
            rd_flags_reg <= f_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_tag_reg <= '0;
        end
        else
        begin
            rd_tag_reg.valid <= rd_en;
            rd_tag_reg.idx   <= rd_addr;
        end
    end

    assign rd_x     = rd_x_reg;
    assign rd_y     = rd_y_reg;
    assign rd_flags = rd_flags_reg;
    assign rd_tag   = rd_tag_reg;

endmodule

[sv/npm_dist.sv]
// npm_dist: pipelined squared-distance unit with running nearest-entry tracker
// depends on npm_pkg
module npm_dist
    import npm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  clear,
    input  logic [COORD_BITS-1:0] off_x,
    input  logic [COORD_BITS-1:0] off_y,
    input  logic [COORD_BITS-1:0] mem_x,
    input  logic [COORD_BITS-1:0] mem_y,
    input  logic [FLAG_W-1:0]     mem_flags,
    input  rd_tag_t               mem_tag,
    output logic                  idle,
    output best_t                 best
);

    logic [COORD_BITS:0]   dx;
    logic [COORD_BITS:0]   dy;
    logic [COORD_BITS-1:0] ux;
    logic [COORD_BITS-1:0] uy;
    logic [D2_W-1:0]       d2;

    logic                  a_valid_reg;
    logic [IDX_W-1:0]      a_idx_reg;
    logic [FLAG_W-1:0]     a_flags_reg;
    logic [COORD_BITS-1:0] a_ux_reg;
    logic [COORD_BITS-1:0] a_uy_reg;

    logic                  b_valid_reg;
    logic [IDX_W-1:0]      b_idx_reg;
    logic [FLAG_W-1:0]     b_flags_reg;
    logic [SQ_W-1:0]       b_sqx_reg;
    logic [SQ_W-1:0]       b_sqy_reg;

    best_t                 best_reg;
    best_t                 best_next;

    // sign-extended difference, magnitude fits in COORD_BITS
    assign dx = {off_x[COORD_BITS-1], off_x} - {mem_x[COORD_BITS-1], mem_x};
    assign dy = {off_y[COORD_BITS-1], off_y} - {mem_y[COORD_BITS-1], mem_y};
    assign ux = COORD_BITS'(dx[COORD_BITS] ? (~dx + 1'b1) : dx);
    assign uy = COORD_BITS'(dy[COORD_BITS] ? (~dy + 1'b1) : dy);

    assign d2 = D2_W'(b_sqx_reg) + D2_W'(b_sqy_reg);

    always_comb
    begin
        best_next = best_reg;
        if (clear)
        begin
            best_next = '0;
        end
        // strict less keeps the lowest index on ties
        else if (b_valid_reg && (!best_reg.found || d2 < best_reg.d2))
        begin
            best_next.found = 1'b1;
            best_next.idx   = b_idx_reg;
            best_next.d2    = d2;
            best_next.flags = b_flags_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_idx_reg   <= mem_tag.idx;
        a_flags_reg <= mem_flags;
        a_ux_reg    <= ux;
        a_uy_reg    <= uy;
        b_idx_reg   <= a_idx_reg;
        b_flags_reg <= a_flags_reg;
        b_sqx_reg   <= a_ux_reg * a_ux_reg;
        b_sqy_reg   <= a_uy_reg * a_uy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            best_reg    <= '0;
        end
        else
        begin
            a_valid_reg <= mem_tag.valid && !clear;
            b_valid_reg <= a_valid_reg && !clear;
            best_reg    <= best_next;
        end
    end

    assign idle = !a_valid_reg && !b_valid_reg;
    assign best = best_reg;

endmodule

[sv/nearest_peak_merge.sv]
// nearest_peak_merge: top level, sequencer, config registers and result register
// depends on npm_pkg, npm_store, npm_dist
//
// channel   direction  handshake             payload
// in        in         in_valid / in_ready   action, pos_x, pos_y, flags_in, batch_last
// out       out        out_valid / out_ready outcome, entry_index, entry_flags, peak_count
// apb       in         psel/penable/pready   paddr, pwrite, pwdata, prdata
//
// an offer with committed peaks holds the block while it reads one stored peak per cycle off
// the single read port, drains the read register, two distance stages and the nearest-entry
// register, decides and goes idle; other words only decide; a decision waits on out_free
// in_ready is low while a word is at work and rises as its result is registered
// the result register lets the next word in while the last result waits on out_ready
// memories are not cleared on reset; the peak counts guard every read
module nearest_peak_merge
    import npm_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ACTION_W-1:0]          action,
    input  logic signed [POS_W-1:0]      pos_x,
    input  logic signed [POS_W-1:0]      pos_y,
    input  logic [FLAGS_IO_W-1:0]        flags_in,
    input  logic                         batch_last,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [OUTCOME_W-1:0]         outcome,
    output logic [ENTRY_IDX_W-1:0]       entry_index,
    output logic [FLAGS_IO_W-1:0]        entry_flags,
    output logic [PEAK_CNT_W-1:0]        peak_count,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_EXEC  = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [IDX_W-1:0]      scan_reg, scan_next;
    logic [CNT_W-1:0]      committed_reg, committed_next;
    logic [CNT_W-1:0]      total_reg, total_next;

    logic [ACTION_W-1:0]   act_reg;
    logic [COORD_BITS-1:0] x_reg;
    logic [COORD_BITS-1:0] y_reg;
    logic [FLAG_W-1:0]     f_reg;
    logic                  last_reg;

    logic                  same_en_reg;
    logic [LIM_W-1:0]      same_lim_reg;
    logic                  new_en_reg;
    logic [LIM_W-1:0]      new_lim_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [OUTCOME_W-1:0]  out_code_reg, out_code_next;
    logic [IDX_W-1:0]      out_idx_reg, out_idx_next;
    logic [FLAG_W-1:0]     out_flags_reg, out_flags_next;
    logic [CNT_W-1:0]      out_cnt_reg, out_cnt_next;

    logic                  in_fire;
    logic                  out_free;
    logic                  cfg_wr;
    logic [1:0]            cfg_sel;

    logic                  wr_pos_en;
    logic                  wr_flag_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [FLAG_W-1:0]     wr_flags;
    logic                  rd_en;

    logic [COORD_BITS-1:0] rd_x;
    logic [COORD_BITS-1:0] rd_y;
    logic [FLAG_W-1:0]     rd_flags;
    rd_tag_t               rd_tag;
    logic                  dist_idle;
    best_t                 best;

    logic [CMP_W-1:0]      d2_q4;
    logic                  do_merge;
    logic                  do_add;
    logic                  is_full;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign is_full  = (total_reg == CNT_W'(PEAK_DEPTH));

    assign d2_q4    = {best.d2, 4'b0000};
    assign do_merge = best.found && same_en_reg && (d2_q4 < CMP_W'(same_lim_reg));
    assign do_add   = new_en_reg && (!best.found || (d2_q4 > CMP_W'(new_lim_reg)));

    assign rd_en    = (state_reg == S_SCAN);

    // config port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = paddr[APB_ADDR_W-1:APB_ADDR_W-2];

    always_comb
    begin
        unique case (cfg_sel)
            REG_SAME_EN:  prdata = APB_DATA_W'(same_en_reg);
            REG_SAME_LIM: prdata = APB_DATA_W'(same_lim_reg);
            REG_NEW_EN:   prdata = APB_DATA_W'(new_en_reg);
            REG_NEW_LIM:  prdata = APB_DATA_W'(new_lim_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            same_en_reg  <= 1'b0;
            same_lim_reg <= '0;
            new_en_reg   <= 1'b0;
            new_lim_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_SAME_EN:  same_en_reg  <= pwdata[0];
                REG_SAME_LIM: same_lim_reg <= pwdata[LIM_W-1:0];
                REG_NEW_EN:   new_en_reg   <= pwdata[0];
                REG_NEW_LIM:  new_lim_reg  <= pwdata[LIM_W-1:0];
                default:      ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        committed_next = committed_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_code_next  = out_code_reg;
        out_idx_next   = out_idx_reg;
        out_flags_next = out_flags_reg;
        out_cnt_next   = out_cnt_reg;
        wr_pos_en      = 1'b0;
        wr_flag_en     = 1'b0;
        wr_addr        = IDX_W'(total_reg);
        wr_flags       = f_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                scan_next = '0;
                if (in_fire)
                begin
                    if (action == ACT_OFFER && committed_reg != '0)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_SCAN:
            begin
                scan_next = scan_reg + 1'b1;
                if (CNT_W'(scan_reg) == committed_reg - 1'b1)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!rd_tag.valid && dist_idle)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    out_idx_next   = '0;
                    out_flags_next = '0;
                    unique case (act_reg)
                        ACT_CLEAR:
                        begin
                            committed_next = '0;
                            total_next     = '0;
                            out_code_next  = OUT_LOADED;
                        end
                        ACT_LOAD:
                        begin
                            if (is_full)
                            begin
                                out_code_next = OUT_FULL;
                            end
                            else
                            begin
                                wr_pos_en      = 1'b1;
                                wr_flag_en     = 1'b1;
                                total_next     = total_reg + 1'b1;
                                committed_next = total_reg + 1'b1;
                                out_code_next  = OUT_LOADED;
                                out_idx_next   = IDX_W'(total_reg);
                                out_flags_next = f_reg;
                            end
                        end
                        ACT_OFFER:
                        begin
                            if (do_merge)
                            begin
                                wr_flag_en     = 1'b1;
                                wr_addr        = best.idx;
                                wr_flags       = best.flags | f_reg;
                                out_code_next  = OUT_MERGED;
                                out_idx_next   = best.idx;
                                out_flags_next = best.flags | f_reg;
                            end
                            else if (do_add)
                            begin
                                if (is_full)
                                begin
                                    out_code_next = OUT_FULL;
                                end
                                else
                                begin
                                    wr_pos_en      = 1'b1;
                                    wr_flag_en     = 1'b1;
                                    total_next     = total_reg + 1'b1;
                                    out_code_next  = OUT_ADDED;
                                    out_idx_next   = IDX_W'(total_reg);
                                    out_flags_next = f_reg;
                                end
                            end
                            else
                            begin
                                out_code_next = OUT_DROPPED;
                                if (best.found)
                                begin
                                    out_idx_next   = best.idx;
                                    out_flags_next = best.flags;
                                end
                            end
                            if (last_reg)
                            begin
                                committed_next = total_next;
                            end
                        end
                        default:
                        begin
                            out_code_next = OUT_DROPPED;
                        end
                    endcase
                    out_cnt_next = total_next;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_reg      <= '0;
            committed_reg <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            committed_reg <= committed_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg  <= action;
            x_reg    <= COORD_BITS'(pos_x);
            y_reg    <= COORD_BITS'(pos_y);
            f_reg    <= FLAG_W'(flags_in);
            last_reg <= batch_last;
        end
        out_code_reg  <= out_code_next;
        out_idx_reg   <= out_idx_next;
        out_flags_reg <= out_flags_next;
        out_cnt_reg   <= out_cnt_next;
    end

    npm_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_pos_en  (wr_pos_en),
        .wr_flag_en (wr_flag_en),
        .wr_addr    (wr_addr),
        .wr_x       (x_reg),
        .wr_y       (y_reg),
        .wr_flags   (wr_flags),
        .rd_en      (rd_en),
        .rd_addr    (scan_reg),
        .rd_x       (rd_x),
        .rd_y       (rd_y),
        .rd_flags   (rd_flags),
        .rd_tag     (rd_tag)
    );

    npm_dist u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (in_fire),
        .off_x      (x_reg),
        .off_y      (y_reg),
        .mem_x      (rd_x),
        .mem_y      (rd_y),
        .mem_flags  (rd_flags),
        .mem_tag    (rd_tag),
        .idle       (dist_idle),
        .best       (best)
    );

    assign out_valid   = out_valid_reg;
    assign outcome     = out_code_reg;
    assign entry_index = ENTRY_IDX_W'(out_idx_reg);
    assign entry_flags = FLAGS_IO_W'(out_flags_reg);
    assign peak_count  = PEAK_CNT_W'(out_cnt_reg);

endmodule
